### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the blob tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/cdbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbt_pkg
// Widths and shared types of the color dominant blob tracker.
// ----------------------------------------------------------------------------
package cdbt_pkg;

    localparam int CHAN_W   = 8;
    localparam int COL_W    = 10;
    localparam int WIDTH_W  = 11;
    localparam int SUM_W    = 32;
    localparam int COUNT_W  = 21;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(64);

    // Classified pixel as it leaves the input stage.
    typedef struct packed {
        logic             object;
        logic             last;
        logic [COL_W-1:0] column;
    } t_pixel;

endpackage

### design/color_dominant_blob_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_dominant_blob_tracker_top
// Counts color-dominant pixels per frame and sums their offsets from center.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless a last pixel waits for the
// result register: a pixel is registered on acceptance, then classified and
// added to the frame accumulators as it leaves the input stage, so throughput
// is one transaction per cycle under that condition, and the result of a frame
// is registered as its last pixel leaves that stage. Only the result register
// can hold things up; while a frame result waits, pixels that are not the last
// of the next frame still flow. The mean offset of the object from center, in
// half columns, is offset_sum / pixel_count, which the user computes downstream.
`include "assert_macros.svh"

module color_dominant_blob_tracker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cdbt_pkg::WIDTH_W-1:0]        i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [cdbt_pkg::CHAN_W-1:0]         i_red,
    input  logic [cdbt_pkg::CHAN_W-1:0]         i_green,
    input  logic [cdbt_pkg::CHAN_W-1:0]         i_blue,
    input  logic [cdbt_pkg::COL_W-1:0]          i_column,
    input  logic                                i_last_in_frame,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [cdbt_pkg::SUM_W-1:0]   o_offset_sum,
    output logic [cdbt_pkg::COUNT_W-1:0]        o_pixel_count
);
    import cdbt_pkg::*;

    logic [WIDTH_W-1:0] r_frame_width;
    logic               r_s1_valid;
    logic [CHAN_W-1:0]  r_red;
    logic [CHAN_W-1:0]  r_green;
    logic [CHAN_W-1:0]  r_blue;
    logic [COL_W-1:0]   r_column;
    logic               r_last;

    logic               object;
    logic               out_free;
    logic               s1_fire;
    logic               in_fire;
    t_pixel             pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_frame_width <= i_cfg_wdata;
        end
    end

    // A last pixel may only leave the input stage when the result register
    // can take the frame totals.
    assign s1_fire    = r_s1_valid && (!r_last || out_free);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_red    <= i_red;
            r_green  <= i_green;
            r_blue   <= i_blue;
            r_column <= i_column;
            r_last   <= i_last_in_frame;
        end
    end

    cdbt_classify u_classify (
        .i_red    (r_red),
        .i_green  (r_green),
        .i_blue   (r_blue),
        .o_object (object)
    );

    assign pixel.object = object;
    assign pixel.last   = r_last;
    assign pixel.column = r_column;

    cdbt_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (s1_fire),
        .i_pixel       (pixel),
        .i_frame_width (r_frame_width),
        .i_out_ready   (i_out_ready),
        .o_out_free    (out_free),
        .o_out_valid   (o_out_valid),
        .o_offset_sum  (o_offset_sum),
        .o_pixel_count (o_pixel_count)
    );

    `ASSERT_IMPLIES(a_last_needs_room, i_clk, i_rst_n, s1_fire && r_last, out_free)
    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, s1_fire && r_last, o_out_valid)
    `ASSERT_IMPLIES(a_empty_stage_ready, i_clk, i_rst_n, !r_s1_valid, o_in_ready)
    `ASSERT_IMPLIES(a_no_pixels_no_sum, i_clk, i_rst_n,
        o_out_valid && (o_pixel_count == '0), o_offset_sum == '0)

endmodule

### design/cdbt_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbt_classify
// Color dominance test: one channel strictly above twice each of the others.
// ----------------------------------------------------------------------------
module cdbt_classify (
    input  logic [cdbt_pkg::CHAN_W-1:0] i_red,
    input  logic [cdbt_pkg::CHAN_W-1:0] i_green,
    input  logic [cdbt_pkg::CHAN_W-1:0] i_blue,
    output logic                        o_object
);
    import cdbt_pkg::*;

    // Doubled channels carry one extra bit so the compare stays exact.
    logic [CHAN_W:0] red_x2;
    logic [CHAN_W:0] green_x2;
    logic [CHAN_W:0] blue_x2;
    logic [CHAN_W:0] red_e;
    logic [CHAN_W:0] green_e;
    logic [CHAN_W:0] blue_e;
    logic            red_dom;
    logic            green_dom;
    logic            blue_dom;

    assign red_x2   = {i_red, 1'b0};
    assign green_x2 = {i_green, 1'b0};
    assign blue_x2  = {i_blue, 1'b0};
    assign red_e    = {1'b0, i_red};
    assign green_e  = {1'b0, i_green};
    assign blue_e   = {1'b0, i_blue};

    assign red_dom   = (red_e > green_x2) && (red_e > blue_x2);
    assign green_dom = (green_e > red_x2) && (green_e > blue_x2);
    assign blue_dom  = (blue_e > red_x2) && (blue_e > green_x2);
    assign o_object  = red_dom || green_dom || blue_dom;

endmodule

### design/cdbt_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbt_accum
// Frame accumulators for the offset sum and pixel count, plus result register.
// ----------------------------------------------------------------------------
module cdbt_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  cdbt_pkg::t_pixel                    i_pixel,
    input  logic [cdbt_pkg::WIDTH_W-1:0]        i_frame_width,
    input  logic                                i_out_ready,
    output logic                                o_out_free,
    output logic                                o_out_valid,
    output logic signed [cdbt_pkg::SUM_W-1:0]   o_offset_sum,
    output logic [cdbt_pkg::COUNT_W-1:0]        o_pixel_count
);
    import cdbt_pkg::*;

    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   r_res_sum;
    logic [COUNT_W-1:0] r_res_count;
    logic               r_out_valid;

    logic [SUM_W-1:0]   offset;
    logic [SUM_W-1:0]   n_sum;
    logic [COUNT_W-1:0] n_count;

    // Offset is 2*column - width, wrapping modulo 2^32 like the accumulator.
    assign offset  = SUM_W'({i_pixel.column, 1'b0}) - SUM_W'(i_frame_width);
    assign n_sum   = i_pixel.object ? (r_sum + offset) : r_sum;
    assign n_count = i_pixel.object ? (r_count + COUNT_W'(1)) : r_count;

    assign o_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_fire) begin
                if (i_pixel.last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                end
            end
            if (i_fire && i_pixel.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_pixel.last) begin
            r_res_sum   <= n_sum;
            r_res_count <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_offset_sum  = $signed(r_res_sum);
    assign o_pixel_count = r_res_count;

endmodule

### tb/cdbt_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbt_frame_checker
// Watches the pixel, configuration and result channels of the blob tracker,
// keeps its own running frame totals and compares every frame result with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module cdbt_frame_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cdbt_pkg::WIDTH_W-1:0]        i_cfg_wdata,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [cdbt_pkg::CHAN_W-1:0]         i_red,
    input  logic [cdbt_pkg::CHAN_W-1:0]         i_green,
    input  logic [cdbt_pkg::CHAN_W-1:0]         i_blue,
    input  logic [cdbt_pkg::COL_W-1:0]          i_column,
    input  logic                                i_last_in_frame,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [cdbt_pkg::SUM_W-1:0]   i_offset_sum,
    input  logic [cdbt_pkg::COUNT_W-1:0]        i_pixel_count,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import cdbt_pkg::*;

    typedef struct packed {
        logic signed [SUM_W-1:0] offset_sum;
        logic [COUNT_W-1:0]      pixel_count;
    } t_frame_totals;

    t_frame_totals           frame_totals_q[$];
    logic [WIDTH_W-1:0]      frame_width = WIDTH_RESET;
    logic signed [SUM_W-1:0] offset_total = '0;
    logic [COUNT_W-1:0]      object_count = '0;
    int                      mismatches = 0;

    // A channel dominates only when it is strictly above twice each other one.
    function automatic logic channel_dominates(input logic [CHAN_W-1:0] a, b, c);
        return ({1'b0, a} > {b, 1'b0}) && ({1'b0, a} > {c, 1'b0});
    endfunction

    function automatic logic is_object_pixel(input logic [CHAN_W-1:0] r, g, b);
        return channel_dominates(r, g, b) || channel_dominates(g, r, b) ||
               channel_dominates(b, r, g);
    endfunction

    always @(posedge i_clk) begin : track_frames
        t_frame_totals want;
        if (!i_rst_n) begin
            frame_width  = WIDTH_RESET;
            offset_total = '0;
            object_count = '0;
            frame_totals_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (frame_totals_q.size() == 0) begin
                    $display("%0t: unexpected frame result, expected none, actual %0d / %0d",
                             $time, i_offset_sum, i_pixel_count);
                    mismatches++;
                end else begin
                    want = frame_totals_q.pop_front();
                    if (i_offset_sum !== want.offset_sum) begin
                        $display("%0t: offset_sum mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.offset_sum), i_offset_sum);
                        mismatches++;
                    end
                    if (i_pixel_count !== want.pixel_count) begin
                        $display("%0t: pixel_count mismatch, expected %0d, actual %0d",
                                 $time, want.pixel_count, i_pixel_count);
                        mismatches++;
                    end
                end
            end

            if (i_cfg_we)
                frame_width = i_cfg_wdata;

            if (i_in_valid && i_in_ready) begin
                if (is_object_pixel(i_red, i_green, i_blue)) begin
                    // The offset wraps at the sum width, like the hardware adder.
                    offset_total = offset_total +
                                   (SUM_W'({i_column, 1'b0}) - SUM_W'(frame_width));
                    object_count = object_count + 1'b1;
                end
                if (i_last_in_frame) begin
                    frame_totals_q.push_back('{offset_sum: offset_total,
                                               pixel_count: object_count});
                    offset_total = '0;
                    object_count = '0;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= frame_totals_q.size();
    end

endmodule

### tb/tb_color_dominant_blob_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_color_dominant_blob_tracker_top
// Drives pixel frames into the blob tracker under several frame widths, with
// random idling on both channels and one long result stall, and reports the
// verdict from the frame checker.
// ----------------------------------------------------------------------------
module tb_color_dominant_blob_tracker_top;
    import cdbt_pkg::*;

    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 400;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_we      = 1'b0;
    logic [WIDTH_W-1:0]      cfg_wdata   = '0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic [CHAN_W-1:0]       red         = '0;
    logic [CHAN_W-1:0]       green       = '0;
    logic [CHAN_W-1:0]       blue        = '0;
    logic [COL_W-1:0]        column      = '0;
    logic                    last_pixel  = 1'b0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic signed [SUM_W-1:0] offset_sum;
    logic [COUNT_W-1:0]      pixel_count;

    int                      fail_count;
    int                      pending;
    int                      items_sent    = 0;
    int                      width_now     = 64;
    logic                    steady        = 1'b0;
    logic                    long_hold_req = 1'b0;
    logic                    hold_done     = 1'b0;
    int                      stall_left    = 0;
    int                      rx_gap;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    color_dominant_blob_tracker_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_red           (red),
        .i_green         (green),
        .i_blue          (blue),
        .i_column        (column),
        .i_last_in_frame (last_pixel),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_offset_sum    (offset_sum),
        .o_pixel_count   (pixel_count)
    );

    cdbt_frame_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_red           (red),
        .i_green         (green),
        .i_blue          (blue),
        .i_column        (column),
        .i_last_in_frame (last_pixel),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_offset_sum    (offset_sum),
        .i_pixel_count   (pixel_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic int frame_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 8);
        if (roll < 95)
            return $urandom_range(9, 40);
        return $urandom_range(41, 120);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_done  <= 1'b0;
        end else if (long_hold_req && !hold_done) begin
            out_ready  <= 1'b0;
            stall_left <= LONG_HOLD;
            hold_done  <= 1'b1;
        end else if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (steady) begin
            out_ready <= 1'b1;
        end else begin
            rx_gap = pick_gap();
            out_ready <= (rx_gap == 0);
            if (rx_gap != 0)
                stall_left <= rx_gap - 1;
        end
    end

    task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b,
                              input logic [COL_W-1:0] col, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        red        <= r;
        green      <= g;
        blue       <= b;
        column     <= col;
        last_pixel <= lst;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Waits until every frame result is in and the pipeline has emptied.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input int w);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= WIDTH_W'(w);
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_now = w;
    endtask

    task automatic random_rgb(output logic [CHAN_W-1:0] r, g, b);
        int ch [3];
        int kind, lead_ch, lead;
        kind    = $urandom_range(0, 9);
        lead_ch = $urandom_range(0, 2);
        if (kind < 5) begin
            lead = $urandom_range(1, 255);
            foreach (ch[i]) ch[i] = $urandom_range(0, (lead - 1) / 2);
            ch[lead_ch] = lead;
        end else if (kind < 7) begin
            // Exactly twice another channel: never dominant.
            lead = $urandom_range(0, 127);
            foreach (ch[i]) ch[i] = $urandom_range(0, lead);
            ch[lead_ch] = 2 * lead;
            ch[(lead_ch + 1) % 3] = lead;
        end else if (kind == 7) begin
            lead = $urandom_range(0, 1) ? 255 : 0;
            foreach (ch[i]) ch[i] = lead;
        end else begin
            foreach (ch[i]) ch[i] = $urandom_range(0, 255);
        end
        r = CHAN_W'(ch[0]);
        g = CHAN_W'(ch[1]);
        b = CHAN_W'(ch[2]);
    endtask

    task automatic send_random_frames(input int n_items, input bit short_frames);
        int goal, len, col_span;
        logic [CHAN_W-1:0] r, g, b;
        logic [COL_W-1:0]  col;
        goal     = items_sent + n_items;
        col_span = (width_now == 0 || width_now > 1024) ? 1024 : width_now;
        while (items_sent < goal) begin
            len = short_frames ? $urandom_range(1, 3) : frame_length();
            if (!short_frames)
                steady <= ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                random_rgb(r, g, b);
                // Most columns lie inside the frame, some beyond its width.
                col = ($urandom_range(0, 4) != 0) ? COL_W'($urandom_range(0, col_span - 1))
                                                  : COL_W'($urandom_range(0, 1023));
                send_pixel(r, g, b, col, i == len - 1);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset width.
        send_pixel(8'd0,   8'd0,   8'd0,   10'd0,    1'b1);
        send_pixel(8'd255, 8'd0,   8'd0,   10'd0,    1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   10'd1023, 1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 10'd63,   1'b0);
        send_pixel(8'd200, 8'd100, 8'd0,   10'd5,    1'b0);
        send_pixel(8'd201, 8'd100, 8'd100, 10'd10,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 10'd20,   1'b0);
        send_pixel(8'd100, 8'd201, 8'd50,  10'd32,   1'b0);
        send_pixel(8'd1,   8'd0,   8'd0,   10'd64,   1'b0);
        send_pixel(8'd0,   8'd1,   8'd0,   10'd31,   1'b1);
        send_pixel(8'd128, 8'd64,  8'd64,  10'd0,    1'b1);
        send_pixel(8'd0,   8'd0,   8'd3,   10'd1,    1'b0);
        send_pixel(8'd2,   8'd1,   8'd0,   10'd2,    1'b0);
        send_pixel(8'd255, 8'd127, 8'd127, 10'd1023, 1'b1);

        send_random_frames(200, 1'b0);
        write_width(1024);
        send_random_frames(350, 1'b0);
        write_width(1);
        send_random_frames(200, 1'b0);
        write_width(0);
        send_random_frames(150, 1'b0);
        write_width(2047);
        send_random_frames(150, 1'b0);
        write_width($urandom_range(2, 1023));
        send_random_frames(200, 1'b0);

        // Back-to-back short frames against a long result stall.
        write_width(640);
        steady        <= 1'b1;
        long_hold_req <= 1'b1;
        send_random_frames(150, 1'b1);
        steady <= 1'b0;

        settle();
        if (fail_count == 0 && pending == 0)
            $display("color_dominant_blob_tracker_top regression: pass");
        else
            $display("color_dominant_blob_tracker_top regression: fail");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("color_dominant_blob_tracker_top regression: fail");
        $finish;
    end

endmodule
